// ----- hdl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and defaults of the sparse set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int unsigned ENTITY_COUNT_DEF = 256;
    localparam int unsigned PAYLOAD_BITS_DEF = 32;

    // fixed field widths of the channels
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned ENTITY_W  = 9;
    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned PAYLOAD_W = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned ENT_OUT_W = 8;
    localparam int unsigned COUNT_W   = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_PRESENT = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    // which source fills the result register
    typedef enum logic [2:0] {
        RES_ERR    = 3'd0,
        RES_SLOT   = 3'd1,
        RES_LOOKUP = 3'd2,
        RES_INSERT = 3'd3,
        RES_ERASE  = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      rd_dense_slot;
        logic      rd_dense_last;
        logic      insert;
        logic      unmap;
        logic      keep_old;
        logic      move;
        logic      post;
        res_kind_t res_kind;
        status_t   err_status;
    } sst_cmd_t;

    typedef struct packed {
        action_t action;
        logic    clr_done;
        logic    ent_bad;
        logic    sidx_bad;
        logic    found;
        logic    full;
        logic    out_free;
    } sst_stat_t;

endpackage

// ----- hdl/sst_if.sv -----
// ----------------------------------------------------------------------------
// sst_req_if / sst_rsp_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface sst_req_if;
    import sst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ENTITY_W-1:0]  entity;
    logic [SLOT_W-1:0]    slot_index;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, action, entity, slot_index, payload, input ready);
    modport sink (input valid, action, entity, slot_index, payload, output ready);
endinterface

interface sst_rsp_if;
    import sst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_out;
    logic [ENT_OUT_W-1:0] entity_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   count_out;

    modport source (output valid, status, slot_out, entity_out, payload_out, count_out,
                    input ready);
    modport sink (input valid, status, slot_out, entity_out, payload_out, count_out,
                  output ready);
endinterface

// ----- hdl/sst_ram.sv -----
// ----------------------------------------------------------------------------
// sst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sst_ram
    import sst_pkg::*;
#(
    parameter int unsigned WIDTH = PAYLOAD_BITS_DEF,
    parameter int unsigned DEPTH = ENTITY_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer of the sparse set table: clearing pass, request decode, lookup and erase steps.
// ----------------------------------------------------------------------------
module sst_ctrl
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  sst_stat_t stat,
    output sst_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLEAR      = 6'b000001,
        S_IDLE       = 6'b000010,
        S_DECIDE     = 6'b000100,
        S_LOOKUP     = 6'b001000,
        S_ERASE_OLD  = 6'b010000,
        S_ERASE_MOVE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    state_next     = S_IDLE;
                    cmd.post       = 1'b1;
                    cmd.res_kind   = RES_ERR;
                    if (stat.action == ACT_READ)
                    begin
                        if (stat.sidx_bad)
                        begin
                            cmd.err_status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.res_kind = RES_SLOT;
                        end
                    end
                    else if (stat.ent_bad)
                    begin
                        cmd.err_status = ST_INVALID;
                    end
                    else
                    begin
                        case (stat.action)
                            ACT_INSERT:
                            begin
                                if (stat.found || stat.full)
                                begin
                                    cmd.err_status = ST_PRESENT;
                                end
                                else
                                begin
                                    cmd.insert   = 1'b1;
                                    cmd.res_kind = RES_INSERT;
                                end
                            end
                            ACT_LOOKUP:
                            begin
                                if (!stat.found)
                                begin
                                    cmd.err_status = ST_ABSENT;
                                end
                                else
                                begin
                                    cmd.post          = 1'b0;
                                    cmd.rd_dense_slot = 1'b1;
                                    state_next        = S_LOOKUP;
                                end
                            end
                            ACT_ERASE:
                            begin
                                if (!stat.found)
                                begin
                                    cmd.err_status = ST_ABSENT;
                                end
                                else
                                begin
                                    // map entry goes first, the map port is free now
                                    cmd.post          = 1'b0;
                                    cmd.rd_dense_slot = 1'b1;
                                    cmd.unmap         = 1'b1;
                                    state_next        = S_ERASE_OLD;
                                end
                            end
                            default:
                            begin
                                cmd.post   = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_LOOKUP:
            begin
                if (stat.out_free)
                begin
                    cmd.post     = 1'b1;
                    cmd.res_kind = RES_LOOKUP;
                    state_next   = S_IDLE;
                end
            end
            S_ERASE_OLD:
            begin
                cmd.keep_old      = 1'b1;
                cmd.rd_dense_last = 1'b1;
                state_next        = S_ERASE_MOVE;
            end
            S_ERASE_MOVE:
            begin
                if (stat.out_free)
                begin
                    cmd.move     = 1'b1;
                    cmd.post     = 1'b1;
                    cmd.res_kind = RES_ERASE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/sst_dpath.sv -----
// ----------------------------------------------------------------------------
// sst_dpath
// Map and dense memories, live count, request latch and result register.
// ----------------------------------------------------------------------------
module sst_dpath
    import sst_pkg::*;
#(
    parameter int unsigned ENTITY_COUNT = ENTITY_COUNT_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sst_cmd_t             cmd,
    output sst_stat_t            stat,
    input  logic [ACTION_W-1:0]  req_action,
    input  logic [ENTITY_W-1:0]  req_entity,
    input  logic [SLOT_W-1:0]    req_slot_index,
    input  logic [PAYLOAD_W-1:0] req_payload,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [STATUS_W-1:0]  rsp_status,
    output logic [SLOT_W-1:0]    rsp_slot_out,
    output logic [ENT_OUT_W-1:0] rsp_entity_out,
    output logic [PAYLOAD_W-1:0] rsp_payload_out,
    output logic [COUNT_W-1:0]   rsp_count_out
);

    localparam int unsigned IW = $clog2(ENTITY_COUNT);
    localparam int unsigned CW = $clog2(ENTITY_COUNT + 1);
    localparam int unsigned MW = IW + 1;
    localparam int unsigned DW = IW + PAYLOAD_BITS;

    // request latch
    action_t                 action_reg;
    logic [ENTITY_W-1:0]     ent_reg;
    logic [SLOT_W-1:0]       sidx_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] old_pay_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] clr_reg;

    // result register
    logic                 rsp_valid_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [ENT_OUT_W-1:0] ent_out_reg;
    logic [ENT_OUT_W-1:0] ent_out_next;
    logic [PAYLOAD_W-1:0] pay_out_reg;
    logic [PAYLOAD_W-1:0] pay_out_next;
    logic [COUNT_W-1:0]   count_out_reg;

    // memory ports
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic [MW-1:0] map_wdata;
    logic [MW-1:0] map_q;
    logic          dense_we;
    logic [IW-1:0] dense_waddr;
    logic [DW-1:0] dense_wdata;
    logic          dense_re;
    logic [IW-1:0] dense_raddr;
    logic [DW-1:0] dense_q;

    logic                    map_valid;
    logic [IW-1:0]           map_slot;
    logic [IW-1:0]           dense_ent;
    logic [PAYLOAD_BITS-1:0] dense_pay;
    logic [IW-1:0]           e_idx;
    logic                    moved_is_e;

    assign map_valid  = map_q[IW];
    assign map_slot   = map_q[IW-1:0];
    assign dense_ent  = dense_q[DW-1:PAYLOAD_BITS];
    assign dense_pay  = dense_q[PAYLOAD_BITS-1:0];
    assign e_idx      = IW'(ent_reg);
    assign moved_is_e = (dense_ent == e_idx);

    sst_ram #(
        .WIDTH (MW),
        .DEPTH (ENTITY_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (cmd.load),
        .raddr (IW'(req_entity)),
        .rdata (map_q)
    );

    sst_ram #(
        .WIDTH (DW),
        .DEPTH (ENTITY_COUNT)
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (dense_re),
        .raddr (dense_raddr),
        .rdata (dense_q)
    );

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = e_idx;
        map_wdata = '0;
        if (cmd.clear)
        begin
            map_we    = 1'b1;
            map_waddr = clr_reg;
        end
        else if (cmd.insert)
        begin
            map_we    = 1'b1;
            map_wdata = {1'b1, IW'(count_reg)};
        end
        else if (cmd.unmap)
        begin
            map_we = 1'b1;
        end
        else if (cmd.move)
        begin
            // the last slot's entity follows its data, unless it is the one erased
            map_we    = !moved_is_e;
            map_waddr = dense_ent;
            map_wdata = {1'b1, map_slot};
        end
    end

    always_comb
    begin
        dense_we    = cmd.insert || cmd.move;
        dense_waddr = map_slot;
        dense_wdata = dense_q;
        if (cmd.insert)
        begin
            dense_waddr = IW'(count_reg);
            dense_wdata = {e_idx, pay_reg};
        end
    end

    always_comb
    begin
        dense_re    = cmd.load || cmd.rd_dense_slot || cmd.rd_dense_last;
        dense_raddr = map_slot;
        if (cmd.load)
        begin
            dense_raddr = IW'(req_slot_index);
        end
        else if (cmd.rd_dense_last)
        begin
            dense_raddr = IW'(count_reg - CW'(1));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.move)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(req_action);
            ent_reg    <= req_entity;
            sidx_reg   <= req_slot_index;
            pay_reg    <= PAYLOAD_BITS'(req_payload);
        end
        if (cmd.keep_old)
        begin
            old_pay_reg <= dense_pay;
        end
    end

    always_comb
    begin
        stat.action   = action_reg;
        stat.clr_done = (clr_reg == IW'(ENTITY_COUNT - 1));
        stat.ent_bad  = (32'(ent_reg) >= 32'(ENTITY_COUNT));
        stat.sidx_bad = (32'(sidx_reg) >= 32'(count_reg));
        stat.found    = map_valid && (32'(map_slot) < 32'(count_reg));
        stat.full     = (count_reg == CW'(ENTITY_COUNT));
        stat.out_free = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        status_next  = ST_OK;
        slot_next    = '0;
        ent_out_next = '0;
        pay_out_next = '0;
        case (cmd.res_kind)
            RES_ERR:
            begin
                status_next = cmd.err_status;
            end
            RES_SLOT:
            begin
                slot_next    = sidx_reg;
                ent_out_next = ENT_OUT_W'(dense_ent);
                pay_out_next = PAYLOAD_W'(dense_pay);
            end
            RES_LOOKUP:
            begin
                slot_next    = SLOT_W'(map_slot);
                ent_out_next = ent_reg[ENT_OUT_W-1:0];
                pay_out_next = PAYLOAD_W'(dense_pay);
            end
            RES_INSERT:
            begin
                slot_next    = SLOT_W'(count_reg);
                ent_out_next = ent_reg[ENT_OUT_W-1:0];
                pay_out_next = PAYLOAD_W'(pay_reg);
            end
            RES_ERASE:
            begin
                slot_next    = SLOT_W'(map_slot);
                ent_out_next = ent_reg[ENT_OUT_W-1:0];
                pay_out_next = PAYLOAD_W'(old_pay_reg);
            end
            default:
            begin
                status_next = cmd.err_status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            ent_out_reg   <= ent_out_next;
            pay_out_reg   <= pay_out_next;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_status      = status_reg;
    assign rsp_slot_out    = slot_reg;
    assign rsp_entity_out  = ent_out_reg;
    assign rsp_payload_out = pay_out_reg;
    assign rsp_count_out   = count_out_reg;

endmodule

// ----- hdl/sparse_set_table.sv -----
// ----------------------------------------------------------------------------
// sparse_set_table
// Sparse set mapping entity ids to packed dense slots with a payload word each.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       contents
//  req      in   valid / ready   action, entity, slot_index, payload
//  rsp      out  valid / ready   status, slot_out, entity_out, payload_out, count_out
//
//  slot read, insert and refused requests pass S_DECIDE only, lookup also S_LOOKUP and
//  erase S_ERASE_OLD and S_ERASE_MOVE, due to the single registered dense read port.
//  after reset a clearing pass over each map entry empties the map, req.ready low.
//  a new item is taken while a finished result waits in the output register;
//  the next result holds in the sequencer until that register drains.
//
module sparse_set_table
    import sst_pkg::*;
#(
    parameter int unsigned ENTITY_COUNT = ENTITY_COUNT_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    sst_cmd_t  cmd;
    sst_stat_t stat;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sst_dpath #(
        .ENTITY_COUNT (ENTITY_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_action      (req.action),
        .req_entity      (req.entity),
        .req_slot_index  (req.slot_index),
        .req_payload     (req.payload),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_slot_out    (rsp.slot_out),
        .rsp_entity_out  (rsp.entity_out),
        .rsp_payload_out (rsp.payload_out),
        .rsp_count_out   (rsp.count_out)
    );

endmodule

// ----- hdl/sst_checker.sv -----
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the sparse set table, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker
    import sst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [STATUS_W-1:0]  rsp_status,
    input logic [SLOT_W-1:0]    rsp_slot_out,
    input logic [ENT_OUT_W-1:0] rsp_entity_out,
    input logic [PAYLOAD_W-1:0] rsp_payload_out
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pending_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // items taken in but not yet handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_slot_out == '0) && (rsp_entity_out == '0) && (rsp_payload_out == '0))
        else $error("refused request carries data");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> (pending_reg != 2'd0))
        else $error("result handed out with no item pending");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> (pending_reg != 2'd2))
        else $error("item taken with two items already held");

endmodule

bind sparse_set_table sst_checker u_sst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_slot_out    (rsp.slot_out),
    .rsp_entity_out  (rsp.entity_out),
    .rsp_payload_out (rsp.payload_out)
);
